FILE: src/char_lcd_i2c_nibble_sequencer_defines.svh
// Assertion macros used by the character LCD sequencer RTL.
`ifndef CHAR_LCD_I2C_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_I2C_NIBBLE_SEQUENCER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CLCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/clcd_pkg.sv
// Types, constants and tables for the character LCD nibble sequencer.
package clcd_pkg;

  typedef enum logic [3:0] {
    CMD_INIT         = 4'd0,
    CMD_ON           = 4'd1,
    CMD_OFF          = 4'd2,
    CMD_CLEAR        = 4'd3,
    CMD_HOME         = 4'd4,
    CMD_SET_CURSOR   = 4'd5,
    CMD_SCROLL_LEFT  = 4'd6,
    CMD_SCROLL_RIGHT = 4'd7,
    CMD_WRITE_CHAR   = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [3:0] command;
    logic [5:0] column;
    logic [7:0] row;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic [7:0] device_write_address;
    logic [7:0] expander_byte;
    logic       last_byte;
  } out_item_t;

  // One queued job: a whole init sequence or a single full LCD op.
  typedef struct packed {
    logic       init;
    logic [7:0] data;
    logic       rs;
    logic       backlight;
  } job_t;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [6:0] ADDR_RESET = 7'h27;

  localparam logic [7:0] OP_CLEAR        = 8'h01;
  localparam logic [7:0] OP_HOME         = 8'h02;
  localparam logic [7:0] OP_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] OP_DISP_CTRL    = 8'h08;
  localparam logic [7:0] OP_SCROLL_LEFT  = 8'h18;
  localparam logic [7:0] OP_SCROLL_RIGHT = 8'h1C;
  localparam logic [7:0] OP_WAKE         = 8'h30;
  localparam logic [7:0] OP_4BIT         = 8'h20;
  localparam logic [7:0] OP_FUNC_SET     = 8'h28;
  localparam logic [7:0] OP_SET_DDRAM    = 8'h80;
  localparam logic [7:0] ROW1_OFFSET     = 8'h40;
  localparam logic [7:0] ROW2_OFFSET     = 8'h14;
  localparam logic [2:0] DC_DISPLAY_ON   = 3'h4;
  localparam logic [7:0] NIBBLE_MASK     = 8'hF0;

  localparam logic [3:0] INIT_HALF_OPS = 4'd5;
  localparam logic [3:0] INIT_LAST_OP  = 4'd9;

  // Init op sequence: five half ops, then five full ops.
  function automatic logic [7:0] init_op(input logic [3:0] idx);
    logic [7:0] op;
    unique case (idx)
      4'd0:               op = 8'h00;
      4'd1, 4'd2, 4'd3:   op = OP_WAKE;
      4'd4:               op = OP_4BIT;
      4'd5:               op = OP_FUNC_SET;
      4'd6:               op = OP_DISP_CTRL | {5'd0, DC_DISPLAY_ON};
      4'd7:               op = OP_CLEAR;
      4'd8:               op = OP_ENTRY_MODE;
      4'd9:               op = OP_HOME;
      default:            op = 8'h00;
    endcase
    return op;
  endfunction

endpackage

FILE: src/clcd_front.sv
// Front end: takes commands, keeps display state, turns commands into jobs.
module clcd_front import clcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_i,
  input  logic     q_full_i,
  output logic     full_o,
  output logic     job_push_o,
  output job_t     job_o
);

  logic       bl_q, bl_d;
  logic [2:0] dc_q, dc_d;
  logic       take;
  logic       known;
  logic [7:0] row_off;
  logic [7:0] cursor;

  assign full_o = q_full_i;
  assign take   = push_i && !q_full_i;

  always_comb begin
    if (in_i.row == 8'd0) begin
      row_off = 8'h00;
    end else if (in_i.row == 8'd2) begin
      row_off = ROW2_OFFSET;
    end else begin
      row_off = ROW1_OFFSET;
    end
    cursor = OP_SET_DDRAM | ({2'b00, in_i.column} + row_off);
  end

  always_comb begin
    bl_d      = bl_q;
    dc_d      = dc_q;
    known     = 1'b1;
    job_o     = '{init: 1'b0, data: 8'h00, rs: 1'b0, backlight: bl_q};
    unique case (in_i.command)
      CMD_INIT: begin
        dc_d       = DC_DISPLAY_ON;
        job_o.init = 1'b1;
      end
      CMD_ON: begin
        bl_d       = 1'b1;
        dc_d       = dc_q | DC_DISPLAY_ON;
        job_o.data = OP_DISP_CTRL | {5'd0, dc_d};
      end
      CMD_OFF: begin
        bl_d       = 1'b0;
        dc_d       = dc_q & ~DC_DISPLAY_ON;
        job_o.data = OP_DISP_CTRL | {5'd0, dc_d};
      end
      CMD_CLEAR:        job_o.data = OP_CLEAR;
      CMD_HOME:         job_o.data = OP_HOME;
      CMD_SET_CURSOR:   job_o.data = cursor;
      CMD_SCROLL_LEFT:  job_o.data = OP_SCROLL_LEFT;
      CMD_SCROLL_RIGHT: job_o.data = OP_SCROLL_RIGHT;
      CMD_WRITE_CHAR: begin
        job_o.data = in_i.character;
        job_o.rs   = 1'b1;
      end
      default:          known = 1'b0;
    endcase
    job_o.backlight = bl_d;
  end

  assign job_push_o = take && known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q <= 1'b1;
      dc_q <= 3'd0;
    end else if (take && known) begin
      bl_q <= bl_d;
      dc_q <= dc_d;
    end
  end

endmodule

FILE: src/clcd_queue.sv
// Short job queue between the front end and the byte sequencer.
module clcd_queue import clcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t             mem_q [QDEPTH];
  logic [QPW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + QPW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + QPW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

endmodule

FILE: src/clcd_back.sv
// Back end: expands jobs into expander bytes, one byte per cycle while the output is not held.
`include "char_lcd_i2c_nibble_sequencer_defines.svh"

module clcd_back import clcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [6:0] cfg_data_i,
  input  job_t       job_i,
  input  logic       job_empty_i,
  output logic       job_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output out_item_t  out_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e     state_q, state_d;
  job_t       job_q;
  logic [3:0] op_idx_q;
  logic       nib_q;
  logic [1:0] phase_q;
  logic [6:0] addr_q;
  logic       out_valid_q;
  out_item_t  out_q;

  logic       running, emit, last, full_op;
  logic [7:0] op, nibble, exp_byte;

  assign running = (state_q == ST_RUN);
  assign emit    = running && (!out_valid_q || pop_i);
  assign op      = job_q.init ? init_op(op_idx_q) : job_q.data;
  assign full_op = !job_q.init || (op_idx_q >= INIT_HALF_OPS);
  assign nibble  = nib_q ? {op[3:0], 4'h0} : (op & NIBBLE_MASK);
  assign exp_byte = nibble | {4'h0, job_q.backlight, (phase_q == 2'd1), 1'b0, job_q.rs};
  assign last    = (phase_q == 2'd2) && nib_q && (!job_q.init || op_idx_q == INIT_LAST_OP);

  assign job_pop_o = !job_empty_i && (!running || (emit && last));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (job_pop_o) state_d = ST_RUN;
      ST_RUN:  if (emit && last && !job_pop_o) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_q <= '{device_write_address: {addr_q, 1'b0},
                 expander_byte: exp_byte, last_byte: last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_idx_q    <= 4'd0;
      nib_q       <= 1'b0;
      phase_q     <= 2'd0;
      addr_q      <= ADDR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        addr_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (job_pop_o) begin
        op_idx_q <= 4'd0;
        nib_q    <= 1'b0;
        phase_q  <= 2'd0;
      end else if (emit) begin
        if (phase_q == 2'd2) begin
          phase_q <= 2'd0;
          if (full_op && !nib_q) begin
            nib_q <= 1'b1;
          end else begin
            nib_q    <= 1'b0;
            op_idx_q <= op_idx_q + 4'd1;
          end
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end
    end
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

  `CLCD_ASSERT(a_init_idx_range, (running && job_q.init) |-> (op_idx_q <= INIT_LAST_OP), "init op index past end")
  `CLCD_ASSERT(a_single_op_idx, (running && !job_q.init) |-> (op_idx_q == 4'd0), "single op advanced past its op")
  `CLCD_ASSERT(a_half_op_nibble, (running && !full_op) |-> !nib_q, "low nibble on a half op")
  `CLCD_ASSERT_ALWAYS(a_phase_range, phase_q != 2'd3, "enable phase out of range")

endmodule

FILE: src/char_lcd_i2c_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer for an I2C port expander.
//
// Each command becomes a run of expander bytes on the result queue: every LCD nibble
// is three bytes (enable low, high, low), so an ordinary command gives 6 bytes and
// init gives 45; unknown command codes give none. The byte sequencer emits at most
// one byte per clock, and stalls while a byte waits and the result side holds pop
// low. A two-entry job queue lets new commands be taken while the sequencer is
// still busy with earlier ones. The expander address register is written through
// the cfg channel, which is always ready.
module char_lcd_i2c_nibble_sequencer import clcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_i,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  logic job_push, job_pop, q_full, q_empty;
  job_t job_in, job_out;

  assign cfg_ready_o = 1'b1;

  clcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  clcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  clcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .job_i       (job_out),
    .job_empty_i (q_empty),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_o)
  );

endmodule
